@@ design/rmset_pkg.sv @@
`timescale 1ns / 1ps

package rmset_pkg;

  // Operations of the per-lane serial arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  // Steps of the per-plane moment and Twiss evaluation.
  typedef enum logic [4:0] {
    STEP_NSQ   = 5'd0,
    STEP_NQP   = 5'd1,
    STEP_SPP   = 5'd2,
    STEP_VP    = 5'd3,
    STEP_NQD   = 5'd4,
    STEP_SDD   = 5'd5,
    STEP_VD    = 5'd6,
    STEP_NC    = 5'd7,
    STEP_SPD   = 5'd8,
    STEP_CQ    = 5'd9,
    STEP_A     = 5'd10,
    STEP_B     = 5'd11,
    STEP_E     = 5'd12,
    STEP_ROOT  = 5'd13,
    STEP_Q     = 5'd14,
    STEP_BETA  = 5'd15,
    STEP_GAMMA = 5'd16,
    STEP_BG    = 5'd17,
    STEP_ALPHA = 5'd18
  } step_e;

  localparam logic [1:0] PLANE_X = 2'd0;
  localparam logic [1:0] PLANE_Y = 2'd1;
  localparam logic [1:0] PLANE_Z = 2'd2;

  localparam int unsigned OUT_DATA_W = 248;
  localparam int unsigned OUT_USER_W = 3;
  // Widest intermediate value the lanes can produce over the parameter range.
  localparam int unsigned SAT_IN_W   = 128;

  typedef struct packed {
    logic               last_plane;
    logic               degenerate;
    logic        [31:0] twiss_alpha;
    logic        [31:0] twiss_gamma;
    logic        [31:0] twiss_beta;
    logic signed [15:0] correlation;
    logic        [31:0] emittance;
    logic signed [32:0] covariance;
    logic        [31:0] dir_variance;
    logic        [31:0] pos_variance;
    logic        [1:0]  plane;
  } result_t;

  function automatic logic [31:0] sat32(input logic [SAT_IN_W-1:0] v);
    logic [31:0] r;
    r = (v > SAT_IN_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : v[31:0];
    return r;
  endfunction

endpackage

@@ design/rmset_accum.sv @@
`timescale 1ns / 1ps

module rmset_accum
  import rmset_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = 65536,
  parameter int unsigned CB            = 16,
  parameter int unsigned CW            = 17,
  parameter int unsigned SW            = 33,
  parameter int unsigned QW            = 49,
  parameter int unsigned XW            = 50
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_last_i,
  input  logic [5:0][CB-1:0]          coord_i,
  input  logic                        clear_i,
  output logic [CW-1:0]               cnt_o,
  output logic [5:0][SW-1:0]          sum_o,
  output logic [5:0][QW-1:0]          sq_o,
  output logic [2:0][XW-1:0]          cross_o,
  output logic                        done_o
);

  logic [CW-1:0]           cnt_q;
  logic                    en1_q, last1_q, en2_q, last2_q, done_q;
  logic [5:0][CB-1:0]      c1_q;
  logic [5:0][CB-1:0]      c2_q;
  logic [5:0][2*CB-1:0]    sq2_q;
  logic [2:0][2*CB-1:0]    xp2_q;
  logic [5:0][SW-1:0]      sum_q;
  logic [5:0][QW-1:0]      sqs_q;
  logic [2:0][XW-1:0]      xs_q;
  logic                    room;

  // Particles beyond the limit still pass through so that a last flag is seen.
  assign room = cnt_q < CW'(MAX_PARTICLES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      en1_q   <= 1'b0;
      last1_q <= 1'b0;
      en2_q   <= 1'b0;
      last2_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (clear_i) begin
        cnt_q <= '0;
      end else if (in_valid_i && room) begin
        cnt_q <= cnt_q + 1'b1;
      end
      en1_q   <= in_valid_i && room;
      last1_q <= in_valid_i && in_last_i;
      en2_q   <= en1_q;
      last2_q <= last1_q;
      done_q  <= last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q <= coord_i;
    c2_q <= c1_q;
    for (int i = 0; i < 6; i++) begin
      sq2_q[i] <= $signed({{CB{c1_q[i][CB-1]}}, c1_q[i]})
                * $signed({{CB{c1_q[i][CB-1]}}, c1_q[i]});
    end
    for (int k = 0; k < 3; k++) begin
      xp2_q[k] <= $signed({{CB{c1_q[2*k][CB-1]}}, c1_q[2*k]})
                * $signed({{CB{c1_q[2*k+1][CB-1]}}, c1_q[2*k+1]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      sqs_q <= '0;
      xs_q  <= '0;
    end else if (clear_i) begin
      sum_q <= '0;
      sqs_q <= '0;
      xs_q  <= '0;
    end else if (en2_q) begin
      for (int i = 0; i < 6; i++) begin
        sum_q[i] <= sum_q[i] + {{(SW-CB){c2_q[i][CB-1]}}, c2_q[i]};
        sqs_q[i] <= sqs_q[i] + {{(QW-2*CB){1'b0}}, sq2_q[i]};
      end
      for (int k = 0; k < 3; k++) begin
        xs_q[k] <= xs_q[k] + {{(XW-2*CB){xp2_q[k][2*CB-1]}}, xp2_q[k]};
      end
    end
  end

  assign cnt_o   = cnt_q;
  assign sum_o   = sum_q;
  assign sq_o    = sqs_q;
  assign cross_o = xs_q;
  assign done_o  = done_q;

endmodule

@@ design/rmset_alu.sv @@
`timescale 1ns / 1ps

module rmset_alu
  import rmset_pkg::*;
#(
  parameter int unsigned AW = 68
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  alu_req_t      req_i,
  input  logic [AW-1:0] a_i,
  input  logic [AW-1:0] b_i,
  output logic          done_o,
  output logic [AW-1:0] res_o
);

  localparam int unsigned CNT_W = $clog2(AW + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  alu_op_e          op_q;
  logic [AW-1:0]    ra_q, rb_q, acc_q, rt_q;
  logic [AW:0]      rem1;
  logic [AW+1:0]    rem2, trial;

  assign rem1  = {acc_q, rb_q[AW-1]};
  assign rem2  = {acc_q, rb_q[AW-1:AW-2]};
  assign trial = {rt_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == OP_SQRT) ? CNT_W'(AW / 2) : CNT_W'(AW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ra_q  <= a_i;
      rb_q  <= b_i;
      acc_q <= '0;
      rt_q  <= '0;
    end else if (busy_q) begin
      unique case (op_q)
        OP_MUL: begin
          if (rb_q[0]) acc_q <= acc_q + ra_q;
          ra_q <= {ra_q[AW-2:0], 1'b0};
          rb_q <= {1'b0, rb_q[AW-1:1]};
        end
        OP_DIV: begin
          // Restoring division, one quotient bit shifted into the dividend register.
          if (rem1 >= {1'b0, ra_q}) begin
            acc_q <= AW'(rem1 - {1'b0, ra_q});
            rb_q  <= {rb_q[AW-2:0], 1'b1};
          end else begin
            acc_q <= rem1[AW-1:0];
            rb_q  <= {rb_q[AW-2:0], 1'b0};
          end
        end
        OP_SQRT: begin
          if (rem2 >= trial) begin
            acc_q <= AW'(rem2 - trial);
            rt_q  <= {rt_q[AW-2:0], 1'b1};
          end else begin
            acc_q <= rem2[AW-1:0];
            rt_q  <= {rt_q[AW-2:0], 1'b0};
          end
          rb_q <= {rb_q[AW-3:0], 2'b00};
        end
        default: begin
          acc_q <= acc_q;
        end
      endcase
    end
  end

  always_comb begin
    case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_DIV:  res_o = (ra_q == '0) ? '0 : rb_q;
      OP_SQRT: res_o = rt_q;
      default: res_o = '0;
    endcase
  end

  assign done_o = done_q;

endmodule

@@ design/rmset_lane.sv @@
`timescale 1ns / 1ps

module rmset_lane
  import rmset_pkg::*;
#(
  parameter int unsigned PLANE = 0,
  parameter int unsigned CW    = 17,
  parameter int unsigned SW    = 33,
  parameter int unsigned QW    = 49,
  parameter int unsigned XW    = 50,
  parameter int unsigned AW    = 68
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [CW-1:0] n_i,
  input  logic [SW-1:0] sum_pos_i,
  input  logic [SW-1:0] sum_dir_i,
  input  logic [QW-1:0] sq_pos_i,
  input  logic [QW-1:0] sq_dir_i,
  input  logic [XW-1:0] cross_i,
  output logic          done_o,
  output result_t       res_o
);

  typedef enum logic [3:0] {
    L_IDLE  = 4'b0001,
    L_ISSUE = 4'b0010,
    L_WAIT  = 4'b0100,
    L_DONE  = 4'b1000
  } lane_state_e;

  lane_state_e   state_q, state_d;
  step_e         step_q, step_d;
  alu_req_t      req;
  logic [AW-1:0] opa, opb, alu_res;
  logic          alu_done;

  logic [AW-1:0] nsq_q, t1_q, vp_q, vd_q, cq_q, pa_q, e_q, root_q;
  logic [AW:0]   cn_q, cn_neg;
  logic          cneg_q;
  logic [15:0]   corr_q;
  logic [31:0]   beta_q, gamma_q, alpha_q;

  logic [SW-1:0] mp, md;
  logic [XW-1:0] mc;
  logic          sc, ss;
  logic [AW-1:0] cn_abs, det, bgm, one32;
  logic [16:0]   qv;

  assign mp     = sum_pos_i[SW-1] ? (~sum_pos_i + 1'b1) : sum_pos_i;
  assign md     = sum_dir_i[SW-1] ? (~sum_dir_i + 1'b1) : sum_dir_i;
  assign mc     = cross_i[XW-1] ? (~cross_i + 1'b1) : cross_i;
  assign sc     = cross_i[XW-1];
  assign ss     = sum_pos_i[SW-1] ^ sum_dir_i[SW-1];
  assign cn_neg = ~cn_q + 1'b1;
  assign cn_abs = cn_q[AW] ? cn_neg[AW-1:0] : cn_q[AW-1:0];
  // A determinant that truncation pushed below zero counts as zero.
  assign det    = (pa_q > t1_q) ? (pa_q - t1_q) : '0;
  assign one32  = AW'(64'h1_0000_0000);
  assign bgm    = (t1_q > one32) ? (t1_q - one32) : '0;

  always_comb begin
    opa    = '0;
    opb    = '0;
    req.op = OP_MUL;
    unique case (step_q)
      STEP_NSQ:   begin opa = AW'(n_i);  opb = AW'(n_i);  end
      STEP_NQP:   begin opa = AW'(n_i);  opb = AW'(sq_pos_i); end
      STEP_SPP:   begin opa = AW'(mp);   opb = AW'(mp);   end
      STEP_VP:    begin req.op = OP_DIV; opa = nsq_q; opb = t1_q; end
      STEP_NQD:   begin opa = AW'(n_i);  opb = AW'(sq_dir_i); end
      STEP_SDD:   begin opa = AW'(md);   opb = AW'(md);   end
      STEP_VD:    begin req.op = OP_DIV; opa = nsq_q; opb = t1_q; end
      STEP_NC:    begin opa = AW'(n_i);  opb = AW'(mc);   end
      STEP_SPD:   begin opa = AW'(mp);   opb = AW'(md);   end
      STEP_CQ:    begin req.op = OP_DIV; opa = nsq_q; opb = cn_abs; end
      STEP_A:     begin opa = vp_q;      opb = vd_q;      end
      STEP_B:     begin opa = cq_q;      opb = cq_q;      end
      STEP_E:     begin req.op = OP_SQRT; opb = det;      end
      STEP_ROOT:  begin req.op = OP_SQRT; opb = pa_q;     end
      STEP_Q:     begin
        req.op = OP_DIV;
        opa    = root_q;
        opb    = {cq_q[AW-16:0], 15'd0};
      end
      STEP_BETA:  begin req.op = OP_DIV; opa = e_q; opb = {vp_q[AW-17:0], 16'd0}; end
      STEP_GAMMA: begin req.op = OP_DIV; opa = e_q; opb = {vd_q[AW-17:0], 16'd0}; end
      STEP_BG:    begin opa = AW'(beta_q); opb = AW'(gamma_q); end
      STEP_ALPHA: begin req.op = OP_SQRT; opb = bgm;      end
      default:    begin opa = '0; end
    endcase
    req.start = (state_q == L_ISSUE);
  end

  rmset_alu #(
    .AW (AW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      L_IDLE, L_DONE: begin
        if (start_i) begin
          state_d = L_ISSUE;
          step_d  = STEP_NSQ;
        end
      end
      L_ISSUE: begin
        state_d = L_WAIT;
      end
      L_WAIT: begin
        if (alu_done) begin
          if (step_q == STEP_ALPHA) begin
            state_d = L_DONE;
          end else begin
            state_d = L_ISSUE;
            step_d  = step_e'(step_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      step_q  <= STEP_NSQ;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Correlation magnitude: full scale when the covariance reaches the root.
  assign qv = (cq_q >= root_q) ? 17'h0_8000 : {1'b0, alu_res[15:0]};

  always_ff @(posedge clk_i) begin
    if (state_q == L_WAIT && alu_done) begin
      case (step_q)
        STEP_NSQ:   nsq_q <= alu_res;
        STEP_NQP:   t1_q  <= alu_res;
        STEP_SPP:   t1_q  <= t1_q - alu_res;
        STEP_VP:    vp_q  <= alu_res;
        STEP_NQD:   t1_q  <= alu_res;
        STEP_SDD:   t1_q  <= t1_q - alu_res;
        STEP_VD:    vd_q  <= alu_res;
        STEP_NC:    cn_q  <= sc ? (~{1'b0, alu_res} + 1'b1) : {1'b0, alu_res};
        STEP_SPD:   cn_q  <= ss ? (cn_q + {1'b0, alu_res}) : (cn_q - {1'b0, alu_res});
        STEP_CQ: begin
          cq_q   <= alu_res;
          cneg_q <= cn_q[AW] && (alu_res != '0);
        end
        STEP_A:     pa_q   <= alu_res;
        STEP_B:     t1_q   <= alu_res;
        STEP_E:     e_q    <= alu_res;
        STEP_ROOT:  root_q <= alu_res;
        STEP_Q: begin
          if (root_q == '0) begin
            corr_q <= 16'd0;
          end else if (cneg_q) begin
            corr_q <= 16'(~qv + 1'b1);
          end else begin
            corr_q <= qv[15] ? 16'h7FFF : qv[15:0];
          end
        end
        STEP_BETA:  beta_q  <= sat32(SAT_IN_W'(alu_res));
        STEP_GAMMA: gamma_q <= sat32(SAT_IN_W'(alu_res));
        STEP_BG:    t1_q    <= alu_res;
        STEP_ALPHA: alpha_q <= sat32(SAT_IN_W'(alu_res));
        default:    t1_q    <= t1_q;
      endcase
    end
  end

  logic degen;
  assign degen = (e_q == '0);

  always_comb begin
    res_o.plane        = 2'(PLANE);
    res_o.pos_variance = sat32(SAT_IN_W'(vp_q));
    res_o.dir_variance = sat32(SAT_IN_W'(vd_q));
    if (cneg_q) begin
      res_o.covariance = (cq_q > AW'(64'h1_0000_0000)) ? 33'h1_0000_0000
                                                       : 33'(~cq_q + 1'b1);
    end else begin
      res_o.covariance = (cq_q > AW'(64'hFFFF_FFFF)) ? 33'h0_FFFF_FFFF : cq_q[32:0];
    end
    res_o.emittance    = sat32(SAT_IN_W'(e_q));
    res_o.correlation  = corr_q;
    res_o.twiss_beta   = degen ? 32'd0 : beta_q;
    res_o.twiss_gamma  = degen ? 32'd0 : gamma_q;
    res_o.twiss_alpha  = degen ? 32'd0 : alpha_q;
    res_o.degenerate   = degen;
    res_o.last_plane   = (2'(PLANE) == PLANE_Z);
  end

  assign done_o = (state_q == L_DONE);

endmodule

@@ design/rms_emittance_twiss_estimator_top.sv @@
`timescale 1ns / 1ps

// Beam moment estimator. One particle beat (x, x', y, y', z, z') is taken every clock
// cycle while tready is high and accumulated through a three-stage multiply-accumulate
// pipeline. On the beat flagged by tlast the input stalls: three parallel lanes, one per
// plane, each step their own serial multiply/divide/square-root unit through 19
// operations, sixteen multiplies and divides and three square roots, all of them AW bits
// wide with AW = max(66, 2*(COORD_BITS+clog2(MAX_PARTICLES+1))). The three plane results
// then leave as beats x, y, z, tlast on z, after which the accumulators are clear and the
// next particle set may start.

module rms_emittance_twiss_estimator_top
  import rmset_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = 65536,
  parameter int unsigned COORD_BITS    = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_pos, x_dir, y_pos, y_dir, z_pos, z_dir, zero fill
  input  logic [((6*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // last_particle
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // pos_variance, dir_variance, covariance, emittance, correlation,
  // twiss_beta, twiss_gamma, twiss_alpha, zero fill
  output logic [OUT_DATA_W-1:0]                 m_axis_tdata,
  // plane, degenerate
  output logic [OUT_USER_W-1:0]                 m_axis_tuser,
  // last_plane
  output logic                                  m_axis_tlast
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned SW = CB + CW;
  localparam int unsigned QW = 2 * CB + CW;
  localparam int unsigned XW = 2 * CB + CW + 1;
  localparam int unsigned AW = (2 * (CW + CB) > 66) ? 2 * (CW + CB) : 66;

  typedef enum logic [3:0] {
    T_ACCUM = 4'b0001,
    T_FLUSH = 4'b0010,
    T_CALC  = 4'b0100,
    T_OUT   = 4'b1000
  } top_state_e;

  top_state_e         state_q, state_d;
  logic               in_acc, out_acc, acc_done, clear, all_done;
  logic [5:0][CB-1:0] coords;
  logic [CW-1:0]      cnt;
  logic [5:0][SW-1:0] sums;
  logic [5:0][QW-1:0] sqs;
  logic [2:0][XW-1:0] xs;
  logic [2:0]         lane_done;
  result_t            lane_res [3];
  result_t            out_q;
  logic               out_valid_q;
  logic [1:0]         idx_q;

  assign s_axis_tready = (state_q == T_ACCUM);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign all_done      = &lane_done;
  assign clear         = (state_q == T_CALC) && all_done;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      coords[i] = s_axis_tdata[i*CB +: CB];
    end
  end

  rmset_accum #(
    .MAX_PARTICLES (MAX_PARTICLES),
    .CB            (CB),
    .CW            (CW),
    .SW            (SW),
    .QW            (QW),
    .XW            (XW)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_acc),
    .in_last_i  (s_axis_tlast),
    .coord_i    (coords),
    .clear_i    (clear),
    .cnt_o      (cnt),
    .sum_o      (sums),
    .sq_o       (sqs),
    .cross_o    (xs),
    .done_o     (acc_done)
  );

  for (genvar k = 0; k < 3; k++) begin : g_lane
    rmset_lane #(
      .PLANE (k),
      .CW    (CW),
      .SW    (SW),
      .QW    (QW),
      .XW    (XW),
      .AW    (AW)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .start_i   ((state_q == T_FLUSH) && acc_done),
      .n_i       (cnt),
      .sum_pos_i (sums[2*k]),
      .sum_dir_i (sums[2*k+1]),
      .sq_pos_i  (sqs[2*k]),
      .sq_dir_i  (sqs[2*k+1]),
      .cross_i   (xs[k]),
      .done_o    (lane_done[k]),
      .res_o     (lane_res[k])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_ACCUM: if (in_acc && s_axis_tlast) state_d = T_FLUSH;
      T_FLUSH: if (acc_done) state_d = T_CALC;
      T_CALC:  if (all_done) state_d = T_OUT;
      T_OUT:   if (out_acc && idx_q == PLANE_Z) state_d = T_ACCUM;
      default: state_d = T_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_ACCUM;
      out_valid_q <= 1'b0;
      idx_q       <= PLANE_X;
    end else begin
      state_q <= state_d;
      if (clear) begin
        out_valid_q <= 1'b1;
        idx_q       <= PLANE_X;
      end else if (out_acc) begin
        if (idx_q == PLANE_Z) begin
          out_valid_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

  // The output register walks through the three lane results, one per beat.
  always_ff @(posedge clk_i) begin
    if (clear) begin
      out_q <= lane_res[PLANE_X];
    end else if (out_acc && idx_q != PLANE_Z) begin
      out_q <= lane_res[idx_q + 1'b1];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.twiss_alpha, out_q.twiss_gamma, out_q.twiss_beta,
                          out_q.correlation, out_q.emittance, out_q.covariance,
                          out_q.dir_variance, out_q.pos_variance};
  assign m_axis_tuser  = {out_q.degenerate, out_q.plane};
  assign m_axis_tlast  = out_q.last_plane;

endmodule
